### rtl/core/mts_pkg.sv
package mts_pkg;

  // data path width of the stored values
  localparam int DATA_W = 32;

  // default stack depth
  localparam int DEPTH_DEF = 16;

  // operation codes
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

  // control sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_FILL = 2'b10
  } state_t;

endpackage

### rtl/core/mts_ram.sv
module mts_ram #(
  parameter int DEPTH = mts_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [mts_pkg::DATA_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [mts_pkg::DATA_W-1:0] rd_data
);
  import mts_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/min_tracking_stack.sv
// push, peek and refused ops give their result in the cycle after the transaction
// a removing pop waits in S_FILL for the registered ram reads, then registers its result
// one item per cycle for push, peek and refused ops while no stalled result holds the input
// a pop stalls the input in S_FILL during the registered read of the value and min rams
// reset: counters, state and output valid are cleared; ram contents stay undefined
module min_tracking_stack #(
  parameter int DEPTH = mts_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_op,
  input  logic signed [mts_pkg::DATA_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [mts_pkg::DATA_W-1:0] out_top_value,
  output logic signed [mts_pkg::DATA_W-1:0] out_min_value,
  output logic                             out_is_empty,
  output logic [1:0]                       out_status
);
  import mts_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [CW-1:0]             mcnt_r, mcnt_nxt;
  logic signed [DATA_W-1:0]  top_r, top_nxt;
  logic signed [DATA_W-1:0]  min_r, min_nxt;
  logic                      min_pop_r, min_pop_nxt;
  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_top_r, out_min_r;
  logic                      out_empty_r;
  logic [1:0]                out_status_r;

  logic                      in_acc;
  logic                      load_out;
  logic [1:0]                stat;
  logic                      wr_val, wr_min;
  logic [CW-1:0]             cnt_m2, mcnt_m2;
  logic [DATA_W-1:0]         val_rd, min_rd;
  logic                      empty_nxt;

  // handshake
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  // read addresses point at the entries below the current tops
  assign cnt_m2  = cnt_r - CW'(2);
  assign mcnt_m2 = mcnt_r - CW'(2);

  // value stack entries
  mts_ram #(.DEPTH(DEPTH), .AW(AW)) u_val_ram (
    .clk     (clk),
    .wr_en   (wr_val),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_value),
    .rd_addr (cnt_m2[AW-1:0]),
    .rd_data (val_rd)
  );

  // auxiliary min stack entries
  mts_ram #(.DEPTH(DEPTH), .AW(AW)) u_min_ram (
    .clk     (clk),
    .wr_en   (wr_min),
    .wr_addr (mcnt_r[AW-1:0]),
    .wr_data (in_value),
    .rd_addr (mcnt_m2[AW-1:0]),
    .rd_data (min_rd)
  );

  // operation sequencer, top entries cached in registers
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    mcnt_nxt    = mcnt_r;
    top_nxt     = top_r;
    min_nxt     = min_r;
    min_pop_nxt = min_pop_r;
    stat        = STAT_OK;
    load_out    = 1'b0;
    wr_val      = 1'b0;
    wr_min      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_PUSH: begin
              load_out = 1'b1;
              if (cnt_r == CW'(DEPTH)) begin
                stat = STAT_OVERFLOW;
              end else begin
                wr_val  = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
                top_nxt = in_value;
                if ((mcnt_r == '0 || in_value <= min_r) && mcnt_r < CW'(DEPTH)) begin
                  wr_min   = 1'b1;
                  mcnt_nxt = mcnt_r + CW'(1);
                  min_nxt  = in_value;
                end
              end
            end
            OP_POP: begin
              if (cnt_r == '0) begin
                load_out = 1'b1;
                stat     = STAT_UNDERFLOW;
              end else begin
                cnt_nxt   = cnt_r - CW'(1);
                state_nxt = S_FILL;
                if (mcnt_r != '0 && top_r == min_r) begin
                  mcnt_nxt    = mcnt_r - CW'(1);
                  min_pop_nxt = 1'b1;
                end else begin
                  min_pop_nxt = 1'b0;
                end
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_FILL: begin
        // ram data for the new tops is back
        top_nxt   = val_rd;
        if (min_pop_r) begin
          min_nxt = min_rd;
        end
        load_out  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign empty_nxt = (cnt_nxt == '0);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      mcnt_r      <= '0;
      min_pop_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      mcnt_r    <= mcnt_nxt;
      min_pop_r <= min_pop_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // cached tops and output payload
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    min_r <= min_nxt;
    if (load_out) begin
      out_top_r    <= empty_nxt ? -DATA_W'(1) : top_nxt;
      out_min_r    <= (empty_nxt || mcnt_nxt == '0) ? '0 : min_nxt;
      out_empty_r  <= empty_nxt;
      out_status_r <= stat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_top_value = out_top_r;
  assign out_min_value = out_min_r;
  assign out_is_empty  = out_empty_r;
  assign out_status    = out_status_r;

endmodule

### tb/sv/min_tracking_stack_test.sv
module min_tracking_stack_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mts_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_AT_ITEM = 500;
  localparam int DRAIN_AT_ITEM = 1000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh80000000;

  // one result of the stack, as seen on the out_ ports
  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic                     is_empty;
    logic [1:0]               status;
  } stack_result_t;

  // stack and min-stack shadow plus the queue of results still owed
  class min_stack_scoreboard;
    logic signed [DATA_W-1:0] value_entries[STACK_DEPTH];
    logic signed [DATA_W-1:0] min_entries[STACK_DEPTH];
    int unsigned              held;
    int unsigned              min_held;
    stack_result_t            owed_q[$];
    int                       mismatches;

    function new();
      held = 0;
      min_held = 0;
      mismatches = 0;
    endfunction

    // apply one accepted transaction and queue the result it must give
    function void note_transaction(logic [1:0] op, logic signed [DATA_W-1:0] value);
      stack_result_t res;
      res.status = STAT_OK;
      case (op)
        OP_PUSH: begin
          if (held >= STACK_DEPTH) begin
            res.status = STAT_OVERFLOW;
          end else begin
            // min stack takes any value at or below the current minimum
            if (min_held == 0 || value <= min_entries[min_held-1]) begin
              if (min_held < STACK_DEPTH) begin
                min_entries[min_held] = value;
                min_held++;
              end
            end
            value_entries[held] = value;
            held++;
          end
        end
        OP_POP: begin
          if (held == 0) begin
            res.status = STAT_UNDERFLOW;
          end else begin
            if (min_held > 0 && value_entries[held-1] == min_entries[min_held-1])
              min_held--;
            held--;
          end
        end
        default: ;
      endcase
      if (held == 0) begin
        res.top_value = -1;
        res.min_value = 0;
        res.is_empty  = 1'b1;
      end else begin
        res.top_value = value_entries[held-1];
        res.min_value = (min_held > 0) ? min_entries[min_held-1] : '0;
        res.is_empty  = 1'b0;
      end
      owed_q.push_back(res);
    endfunction

    function void report(string msg);
      if (mismatches < 10)
        $display("%s", msg);
      mismatches++;
    endfunction

    // compare one accepted result against the oldest owed one
    function void check_result(stack_result_t got);
      stack_result_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("result with nothing owed: top %0d min %0d empty %0b status %0d",
                         got.top_value, got.min_value, got.is_empty, got.status));
        return;
      end
      want = owed_q.pop_front();
      if (got !== want)
        report($sformatf("mismatch at %0t: top %0d/%0d min %0d/%0d empty %0b/%0b status %0d/%0d",
                         $time, want.top_value, got.top_value, want.min_value,
                         got.min_value, want.is_empty, got.is_empty, want.status,
                         got.status));
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_op = OP_PEEK;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_top_value;
  logic signed [DATA_W-1:0] out_min_value;
  logic                     out_is_empty;
  logic [1:0]               out_status;

  bit                       hold_request = 1'b0;
  int unsigned              quiet_cycles = 0;
  min_stack_scoreboard      sb = new();

  min_tracking_stack #(
    .DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_top_value(out_top_value),
    .out_min_value(out_min_value),
    .out_is_empty (out_is_empty),
    .out_status   (out_status)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // small values give equal minimums often; the rest covers the full range
  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $signed($urandom_range(0, 8)) - 4;
    if (r == 5) begin
      case ($urandom_range(0, 3))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return -1;
        default: return 0;
      endcase
    end
    return $urandom();
  endfunction

  // offer one transaction and hold it until accepted
  task automatic send_transaction(input logic [1:0] op, input logic signed [DATA_W-1:0] value);
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_transaction(op, value);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles == 0) return;
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_and_gap(input logic [1:0] op, input logic signed [DATA_W-1:0] value);
    send_transaction(op, value);
    idle_sender(gap_len());
  endtask

  // result side: random stalls, quiet stretches and one long hold on request
  initial begin
    bit stall_v;
    int run;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall_v = 1'b1;
        run = HOLD_CYCLES;
      end else if ($urandom_range(0, 19) == 0) begin
        stall_v = 1'b0;
        run = $urandom_range(30, 120);
      end else begin
        stall_v = ($urandom_range(0, 2) == 0);
        run = stall_v ? gap_len() : $urandom_range(1, 6);
        if (run == 0) run = 1;
      end
      out_stall <= stall_v;
      repeat (run) @(posedge clk);
    end
  end

  // result checking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_result('{out_top_value, out_min_value, out_is_empty, out_status});
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int round_left;
    int push_pct;
    bit burst;
    int r;
    logic [1:0] op;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty stack: peek, refused pop, unused op code
    send_and_gap(OP_PEEK, 0);
    send_and_gap(OP_POP, VAL_MAX);
    send_and_gap(OP_RESERVED, -1);
    // fill with extremes and repeated minimums
    send_and_gap(OP_PUSH, 5);
    send_and_gap(OP_PUSH, 5);
    send_and_gap(OP_PUSH, VAL_MAX);
    send_and_gap(OP_PUSH, 3);
    send_and_gap(OP_PUSH, -1);
    send_and_gap(OP_PUSH, 0);
    send_and_gap(OP_PUSH, 7);
    send_and_gap(OP_PUSH, 100);
    send_and_gap(OP_PUSH, 2);
    send_and_gap(OP_PUSH, 1);
    send_and_gap(OP_PUSH, 1);
    send_and_gap(OP_PUSH, -5);
    send_and_gap(OP_PUSH, -5);
    send_and_gap(OP_PUSH, VAL_MIN);
    send_and_gap(OP_PUSH, VAL_MIN);
    send_and_gap(OP_PUSH, VAL_MIN + 1);
    // full stack: refused push, then peeks and pops through equal minimums
    send_and_gap(OP_PUSH, 9);
    send_and_gap(OP_RESERVED, VAL_MIN);
    send_and_gap(OP_PEEK, VAL_MAX);
    send_and_gap(OP_POP, 0);
    send_and_gap(OP_POP, -1);
    send_and_gap(OP_POP, VAL_MAX);

    // random walk with push-heavy and pop-heavy rounds
    round_left = 0;
    push_pct = 50;
    burst = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (round_left == 0) begin
        round_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0: push_pct = 75;
          1: push_pct = 50;
          default: push_pct = 25;
        endcase
        burst = ($urandom_range(0, 5) == 0);
      end
      // long result hold while pushes keep coming back to back
      if (n == HOLD_AT_ITEM) begin
        hold_request = 1'b1;
        push_pct = 80;
        round_left = 80;
        burst = 1'b1;
      end
      // pause until every owed result is back
      if (n == DRAIN_AT_ITEM) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      r = $urandom_range(0, 99);
      if (r < push_pct) op = OP_PUSH;
      else if (r < 94) op = OP_POP;
      else if (r < 97) op = OP_PEEK;
      else op = OP_RESERVED;
      send_transaction(op, pick_value());
      if (!burst) idle_sender(gap_len());
      round_left--;
    end

    // drain, then watch for stray results
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
